FILE: design/png_chunk_header_parser_assert.svh
// Assertion macros shared by the PNG chunk header parser modules.
`ifndef PNG_CHUNK_HEADER_PARSER_ASSERT_SVH
`define PNG_CHUNK_HEADER_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off while rst is high.
`define PCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("png_cp assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define PCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("png_cp assertion failed");

`else

`define PCP_ASSERT_IMPL(lbl, ante, cons)
`define PCP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: design/png_cp_pkg.sv
// Types, codes and constants for the PNG chunk header parser.
`timescale 1ns / 1ps

package png_cp_pkg;

  localparam int LimitW = 25;
  localparam int OffW   = 25;

  localparam logic [LimitW-1:0] LIMIT_RESET = 25'h100_0000;

  // Parse phases
  localparam logic [2:0] PH_SIG     = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC     = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_OVERSIZE  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_NO_IHDR   = 3'd4;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [31:0] IHDR_LEN  = 32'd13;

  // One input beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  depth;
    logic [7:0]  color;
    logic [7:0]  interlace;
    logic        terminated;
    logic [31:0] byte_total;
  } res_t;

  // PNG file signature
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      3'd7:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/png_cp_core.sv
// Parse state and per-byte update of the PNG chunk walker.
`timescale 1ns / 1ps
`include "png_chunk_header_parser_assert.svh"

module png_cp_core
  import png_cp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [LimitW-1:0] max_len,
  input  logic              take,
  input  beat_t             beat,
  output res_t              res
);

  logic [2:0]      phase, phase_next;
  logic [OffW-1:0] offset, offset_next;
  logic [31:0]     clen, clen_next;
  logic [31:0]     ctype, ctype_next;
  logic [31:0]     wid, wid_next;
  logic [31:0]     hgt, hgt_next;
  logic [7:0]      dep, dep_next;
  logic [7:0]      col, col_next;
  logic [7:0]      ilc, ilc_next;
  logic            ihdr_seen, ihdr_seen_next;
  logic            iend_seen, iend_seen_next;
  logic [2:0]      err, err_next;
  logic [31:0]     count, count_next;

  logic [OffW:0]   off_inc;
  logic            is_ihdr;
  logic [2:0]      st;
  logic            ok;

  assign off_inc = {1'b0, offset} + {{OffW{1'b0}}, 1'b1};
  assign is_ihdr = (ctype == TYPE_IHDR) && (clen == IHDR_LEN);

  always_comb begin
    phase_next     = phase;
    offset_next    = offset;
    clen_next      = clen;
    ctype_next     = ctype;
    wid_next       = wid;
    hgt_next       = hgt;
    dep_next       = dep;
    col_next       = col;
    ilc_next       = ilc;
    ihdr_seen_next = ihdr_seen;
    iend_seen_next = iend_seen;
    err_next       = err;
    count_next     = (count == 32'hFFFF_FFFF) ? count : count + 32'd1;

    case (phase)
      PH_SIG: begin
        if (beat.data != sig_byte(offset[2:0])) begin
          err_next   = ST_BAD_SIG;
          phase_next = PH_DONE;
        end else if (offset[2:0] == 3'd7) begin
          phase_next  = PH_PREFIX;
          offset_next = '0;
        end else begin
          offset_next = off_inc[OffW-1:0];
        end
      end
      PH_PREFIX: begin
        if (!offset[2]) clen_next = {clen[23:0], beat.data};
        else            ctype_next = {ctype[23:0], beat.data};
        if (offset[2:0] == 3'd7) begin
          offset_next = '0;
          if (clen_next > {7'd0, max_len}) begin
            err_next   = ST_OVERSIZE;
            phase_next = PH_DONE;
          end else if (clen_next == 32'd0) begin
            // empty payload: chunk ends with its prefix
            if (ctype_next == TYPE_IEND) begin
              iend_seen_next = 1'b1;
              phase_next     = PH_DONE;
            end else begin
              phase_next = PH_CRC;
            end
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          offset_next = off_inc[OffW-1:0];
        end
      end
      PH_PAYLOAD: begin
        if (is_ihdr) begin
          if (offset < 25'd4)        wid_next = {wid[23:0], beat.data};
          else if (offset < 25'd8)   hgt_next = {hgt[23:0], beat.data};
          else if (offset == 25'd8)  dep_next = beat.data;
          else if (offset == 25'd9)  col_next = beat.data;
          else if (offset == 25'd12) ilc_next = beat.data;
        end
        if ({6'd0, off_inc} >= clen) begin
          offset_next = '0;
          if (is_ihdr) ihdr_seen_next = 1'b1;
          if (ctype == TYPE_IEND) begin
            iend_seen_next = 1'b1;
            phase_next     = PH_DONE;
          end else begin
            phase_next = PH_CRC;
          end
        end else begin
          offset_next = off_inc[OffW-1:0];
        end
      end
      PH_CRC: begin
        if (offset[1:0] == 2'd3) begin
          offset_next = '0;
          clen_next   = '0;
          ctype_next  = '0;
          phase_next  = PH_PREFIX;
        end else begin
          offset_next = off_inc[OffW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Status as seen after this byte
  always_comb begin
    if (err_next != ST_OK)              st = err_next;
    else if (phase_next == PH_SIG)      st = ST_BAD_SIG;
    else if (phase_next == PH_PAYLOAD)  st = ST_TRUNCATED;
    else if (!ihdr_seen_next)           st = ST_NO_IHDR;
    else                                st = ST_OK;
  end

  assign ok = (st == ST_OK);

  always_comb begin
    res.status     = st;
    res.width      = ok ? wid_next : '0;
    res.height     = ok ? hgt_next : '0;
    res.depth      = ok ? dep_next : '0;
    res.color      = ok ? col_next : '0;
    res.interlace  = ok ? ilc_next : '0;
    res.terminated = ok && iend_seen_next;
    res.byte_total = count_next;
  end

  // Reset or a taken final byte returns everything to the start of a new file
  always_ff @(posedge clk) begin
    if (rst || (take && beat.last)) begin
      phase     <= PH_SIG;
      offset    <= '0;
      clen      <= '0;
      ctype     <= '0;
      wid       <= '0;
      hgt       <= '0;
      dep       <= '0;
      col       <= '0;
      ilc       <= '0;
      ihdr_seen <= 1'b0;
      iend_seen <= 1'b0;
      err       <= ST_OK;
      count     <= '0;
    end else if (take) begin
      phase     <= phase_next;
      offset    <= offset_next;
      clen      <= clen_next;
      ctype     <= ctype_next;
      wid       <= wid_next;
      hgt       <= hgt_next;
      dep       <= dep_next;
      col       <= col_next;
      ilc       <= ilc_next;
      ihdr_seen <= ihdr_seen_next;
      iend_seen <= iend_seen_next;
      err       <= err_next;
      count     <= count_next;
    end
  end

  `PCP_ASSERT_NEXT(a_last_clears, take && beat.last, phase == PH_SIG && count == 32'd0)
  `PCP_ASSERT_IMPL(a_payload_nonzero, phase == PH_PAYLOAD, clen != 32'd0)
  `PCP_ASSERT_IMPL(a_err_stops, err != ST_OK, phase == PH_DONE)

endmodule

FILE: design/png_cp_result.sv
// Result register with valid/ready handshake.
`timescale 1ns / 1ps

module png_cp_result
  import png_cp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output logic free,
  output res_t res_q
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

FILE: design/png_chunk_header_parser.sv
// Top level of the PNG chunk header parser.
// A byte is registered in the input register on acceptance and parsed from there;
//   the result beat of a final byte is registered in the result register.
// Throughput: one byte per cycle; a final byte waits in the input register only while
//   the result register is full and unread.
// Reset (rst, synchronous, active high) clears parse state and valids and sets
//   the length limit (max_len) to 1<<24.
`timescale 1ns / 1ps
`include "png_chunk_header_parser_assert.svh"

module png_chunk_header_parser
  import png_cp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LimitW-1:0] max_chunk_length,
  // byte input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [31:0]       image_width,
  output logic [31:0]       image_height,
  output logic [7:0]        sample_depth,
  output logic [7:0]        color_kind,
  output logic [7:0]        interlace_method,
  output logic              terminated,
  output logic [31:0]       byte_total
);

  logic [LimitW-1:0] max_len;
  logic              s1_valid;
  beat_t             s1_beat;
  logic              advance;
  logic              res_free;
  logic              res_load;
  res_t              res_c;
  res_t              res_q;

  // Length limit: taken every cycle; the user must write it only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LIMIT_RESET;
    end else if (cfg_valid) begin
      max_len <= max_chunk_length;
    end
  end

  // Input register. A plain byte always moves on; a final byte needs room in
  // the result register, so the input side stalls only behind an unread result.
  assign advance  = s1_valid && (!s1_beat.last || res_free);
  assign in_ready = !s1_valid || advance;
  assign res_load = advance && s1_beat.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat.data <= data_byte;
      s1_beat.last <= last_byte;
    end
  end

  // Per-byte parse: signature, length/type prefix, payload, CRC skip
  png_cp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .max_len (max_len),
    .take    (advance),
    .beat    (s1_beat),
    .res     (res_c)
  );

  // Result beat held until taken
  png_cp_result u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res_c),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (res_free),
    .res_q     (res_q)
  );

  assign status           = res_q.status;
  assign image_width      = res_q.width;
  assign image_height     = res_q.height;
  assign sample_depth     = res_q.depth;
  assign color_kind       = res_q.color;
  assign interlace_method = res_q.interlace;
  assign terminated       = res_q.terminated;
  assign byte_total       = res_q.byte_total;

  `PCP_ASSERT_NEXT(a_load_shows, res_load, out_valid)
  `PCP_ASSERT_IMPL(a_stall_cause, !in_ready, s1_valid && s1_beat.last && out_valid)
  `PCP_ASSERT_NEXT(a_in_lands, in_valid && in_ready, s1_valid)

endmodule

FILE: tb/sv/png_cp_checker.sv
// Checker for the PNG chunk header parser: predicts each file report and compares it.
`timescale 1ns / 1ps

module png_cp_checker
  import png_cp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LimitW-1:0] cfg_limit,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        status,
  input  logic [31:0]       image_width,
  input  logic [31:0]       image_height,
  input  logic [7:0]        sample_depth,
  input  logic [7:0]        color_kind,
  input  logic [7:0]        interlace_method,
  input  logic              terminated,
  input  logic [31:0]       byte_total,
  output int                mismatches,
  output int                reports_due
);

  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

  logic [LimitW-1:0] limit_q;
  logic [2:0]        phase;
  logic [OffW-1:0]   offset;
  logic [31:0]       clen, ctype, width_q, height_q, byte_tally;
  logic [7:0]        depth_q, color_q, ilace_q;
  logic              ihdr_ok, iend_ok;
  logic [2:0]        err_q;
  res_t              file_reports[$];
  int                fault_tally = 0;

  task automatic wipe_parse();
    phase      = PH_SIG;
    offset     = '0;
    clen       = '0;
    ctype      = '0;
    width_q    = '0;
    height_q   = '0;
    depth_q    = '0;
    color_q    = '0;
    ilace_q    = '0;
    ihdr_ok    = 1'b0;
    iend_ok    = 1'b0;
    err_q      = ST_OK;
    byte_tally = '0;
  endtask

  // end of payload, or end of prefix for an empty chunk
  task automatic close_payload();
    if (ctype == TYPE_IHDR && clen == IHDR_LEN) ihdr_ok = 1'b1;
    offset = '0;
    if (ctype == TYPE_IEND) begin
      iend_ok = 1'b1;
      phase   = PH_DONE;
    end else begin
      phase = PH_CRC;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic lst);
    res_t       rep;
    logic [2:0] st;
    logic       good;
    if (byte_tally != 32'hFFFF_FFFF) byte_tally = byte_tally + 32'd1;
    case (phase)
      PH_SIG: begin
        if (b != PNG_MAGIC[63 - 8*offset[2:0] -: 8]) begin
          err_q = ST_BAD_SIG;
          phase = PH_DONE;
        end else if (offset == 7) begin
          phase  = PH_PREFIX;
          offset = '0;
        end else begin
          offset = offset + 1'b1;
        end
      end
      PH_PREFIX: begin
        if (offset < 4) clen = {clen[23:0], b};
        else ctype = {ctype[23:0], b};
        if (offset == 7) begin
          offset = '0;
          if (clen > {7'd0, limit_q}) begin
            err_q = ST_OVERSIZE;
            phase = PH_DONE;
          end else if (clen == 0) begin
            close_payload();
          end else begin
            phase = PH_PAYLOAD;
          end
        end else begin
          offset = offset + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (ctype == TYPE_IHDR && clen == IHDR_LEN) begin
          if (offset < 4) width_q = {width_q[23:0], b};
          else if (offset < 8) height_q = {height_q[23:0], b};
          else if (offset == 8) depth_q = b;
          else if (offset == 9) color_q = b;
          else if (offset == 12) ilace_q = b;
        end
        if ({7'd0, offset} + 32'd1 >= clen) close_payload();
        else offset = offset + 1'b1;
      end
      PH_CRC: begin
        if (offset == 3) begin
          offset = '0;
          clen   = '0;
          ctype  = '0;
          phase  = PH_PREFIX;
        end else begin
          offset = offset + 1'b1;
        end
      end
      default: ;
    endcase

    if (lst) begin
      if (err_q != ST_OK) st = err_q;
      else if (phase == PH_SIG) st = ST_BAD_SIG;
      else if (phase == PH_PAYLOAD) st = ST_TRUNCATED;
      else if (!ihdr_ok) st = ST_NO_IHDR;
      else st = ST_OK;
      good           = (st == ST_OK);
      rep.status     = st;
      rep.width      = good ? width_q : '0;
      rep.height     = good ? height_q : '0;
      rep.depth      = good ? depth_q : '0;
      rep.color      = good ? color_q : '0;
      rep.interlace  = good ? ilace_q : '0;
      rep.terminated = good && iend_ok;
      rep.byte_total = byte_tally;
      file_reports.insert(file_reports.size(), rep);
      wipe_parse();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fault_tally++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      wipe_parse();
      limit_q = LIMIT_RESET;
      file_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (file_reports.size() == 0) begin
          fault_tally++;
          $display("%0t: unexpected report, expected none, got status %h byte_total %h",
                   $time, status, byte_total);
        end else begin
          want = file_reports.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("image_width", want.width, image_width);
          check_field("image_height", want.height, image_height);
          check_field("sample_depth", 32'(want.depth), 32'(sample_depth));
          check_field("color_kind", 32'(want.color), 32'(color_kind));
          check_field("interlace_method", 32'(want.interlace), 32'(interlace_method));
          check_field("terminated", 32'(want.terminated), 32'(terminated));
          check_field("byte_total", want.byte_total, byte_total);
        end
      end
      if (cfg_valid && cfg_ready) limit_q = cfg_limit;
      if (in_valid && in_ready) predict_byte(data_byte, last_byte);
    end
    mismatches  <= fault_tally;
    reports_due <= file_reports.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench top for the PNG chunk header parser: file stimulus, flow control, verdict.
`timescale 1ns / 1ps

module testbench;
  import png_cp_pkg::*;

  localparam logic [63:0] PNG_MAGIC   = 64'h8950_4E47_0D0A_1A0A;
  localparam int          HOLD_CYCLES = 300;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [LimitW-1:0] chunk_limit = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte   = '0;
  logic              last_byte   = 1'b0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [2:0]        status;
  logic [31:0]       image_width, image_height, byte_total;
  logic [7:0]        sample_depth, color_kind, interlace_method;
  logic              terminated;

  int mismatches;
  int reports_due;

  // receiver flow control: long hold-offs are requested by ticket, served below
  int          hold_ticket = 0;
  int          hold_served = 0;
  int          hold_left   = 0;
  logic [31:0] stall_pat   = '1;
  int          pat_age     = 0;
  logic        open_run    = 1'b1;

  // sender side
  logic [7:0]        file_q[$];        // bytes of the file being built
  logic [LimitW-1:0] limit_now = LIMIT_RESET; // mirror of the limit, shapes lengths only
  bit                steady     = 1'b0; // no gaps between beats
  int                burst_left = 0;
  int                bytes_sent = 0;
  int                files_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  png_chunk_header_parser i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .max_chunk_length (chunk_limit),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .image_width      (image_width),
    .image_height     (image_height),
    .sample_depth     (sample_depth),
    .color_kind       (color_kind),
    .interlace_method (interlace_method),
    .terminated       (terminated),
    .byte_total       (byte_total)
  );

  png_cp_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_limit        (chunk_limit),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .image_width      (image_width),
    .image_height     (image_height),
    .sample_depth     (sample_depth),
    .color_kind       (color_kind),
    .interlace_method (interlace_method),
    .terminated       (terminated),
    .byte_total       (byte_total),
    .mismatches       (mismatches),
    .reports_due      (reports_due)
  );

  // Result side. A pending ticket starts a long hold-off; otherwise a random
  // 32-bit stall pattern is rotated, reloaded when its age runs out, and now
  // and then replaced by a fully open run.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (pat_age == 0) begin
      stall_pat <= $urandom;
      pat_age   <= $urandom_range(8, 64);
      open_run  <= ($urandom_range(0, 3) == 0);
      out_ready <= 1'b1;
    end else begin
      pat_age   <= pat_age - 1;
      out_ready <= open_run | stall_pat[0];
      stall_pat <= {stall_pat[0], stall_pat[31:1]};
    end
  end

  // ---- file building ----

  // appends one byte to the file being built
  task automatic add_byte(input logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endtask

  task automatic put_bytes(input int n);
    logic [7:0] r;
    repeat (n) begin
      r = $urandom;
      add_byte(r);
    end
  endtask

  // big-endian, as PNG lengths and types are
  task automatic put_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) add_byte(w[8*k +: 8]);
  endtask

  task automatic put_sig();
    for (int k = 7; k >= 0; k--) add_byte(PNG_MAGIC[8*k +: 8]);
  endtask

  // length, type, random payload of that length, random CRC
  task automatic put_chunk(input logic [31:0] len, input logic [31:0] ctype);
    put_word(len);
    put_word(ctype);
    put_bytes(len);
    put_bytes(4);
  endtask

  // well-formed IHDR; compression and filter bytes are not latched so are random
  task automatic put_ihdr(input logic [31:0] w, input logic [31:0] h,
                          input logic [7:0] depth, input logic [7:0] color,
                          input logic [7:0] ilace);
    put_word(IHDR_LEN);
    put_word(TYPE_IHDR);
    put_word(w);
    put_word(h);
    add_byte(depth);
    add_byte(color);
    put_bytes(2);
    add_byte(ilace);
    put_bytes(4);
  endtask

  task automatic put_ihdr_random();
    put_ihdr($urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic cut_to(input int n);
    while (file_q.size() > n) file_q.delete(file_q.size() - 1);
  endtask

  // Mostly short payloads, the odd longer one, never above the limit.
  function automatic logic [31:0] pick_len();
    logic [31:0] n;
    if ($urandom_range(0, 24) == 0) n = $urandom_range(20, 300);
    else n = $urandom_range(0, 12);
    if (n > limit_now) n = limit_now;
    return n;
  endfunction

  function automatic logic [31:0] pick_oversize();
    logic [31:0] n;
    case ($urandom_range(0, 2))
      0:       n = limit_now + 32'd1;
      1:       n = 32'hFFFF_FFFF;
      default: begin
        n = $urandom;
        if (n <= limit_now) n = limit_now + 32'd1 + $urandom_range(0, 999);
      end
    endcase
    return n;
  endfunction

  // Mostly well-formed files with random content; the rest is noise, broken
  // signatures and oversize lengths. A quarter of the good ones get cut short,
  // which lands the end in the signature, a prefix, a payload or a CRC.
  task automatic build_random_file();
    int         kind;
    int         idx;
    logic [7:0] flip;
    kind = $urandom_range(0, 9);
    case (kind)
      0: put_bytes($urandom_range(1, 20));
      1: begin
        put_sig();
        idx  = $urandom_range(0, 7);
        flip = $urandom_range(1, 255);
        file_q[idx] = file_q[idx] ^ flip;
        put_bytes($urandom_range(0, 6));
      end
      2: begin
        put_sig();
        if ($urandom_range(0, 1) == 1) put_ihdr_random();
        put_word(pick_oversize());
        put_word($urandom);
        put_bytes($urandom_range(0, 4));
      end
      default: begin
        put_sig();
        if ($urandom_range(0, 9) != 0) put_ihdr_random();
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 7))
            0:       put_ihdr_random();              // overwrites the header
            1:       put_chunk(pick_len(), TYPE_IHDR); // usually wrong length
            default: put_chunk(pick_len(), $urandom);
          endcase
        end
        if ($urandom_range(0, 4) != 0) begin
          put_chunk(($urandom_range(0, 5) == 0) ? pick_len() : 32'd0, TYPE_IEND);
          put_bytes($urandom_range(0, 3));            // trailing bytes, only counted
        end
      end
    endcase
    if (kind >= 3 && $urandom_range(0, 3) == 0) cut_to($urandom_range(1, file_q.size()));
  endtask

  // ---- beat driving ----

  // Offers one beat and returns at the edge where it is taken. Gaps come
  // between bursts of random length unless steady is set.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (!steady) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic ship_file();
    for (int k = 0; k < file_q.size(); k++) send_byte(file_q[k], k == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  // Stop offering and wait for every report; then let the input register and
  // the result register settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LimitW-1:0] v);
    drain();
    cfg_valid   <= 1'b1;
    chunk_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  task automatic run_random_phase(input int min_bytes, input int min_files);
    int b0;
    int f0;
    b0 = bytes_sent;
    f0 = files_sent;
    while (bytes_sent - b0 < min_bytes || files_sent - f0 < min_files) begin
      build_random_file();
      ship_file();
    end
  endtask

  // ---- stimulus and verdict ----

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // default limit: directed files
    put_sig();                                   // signature only: no IHDR
    ship_file();
    put_sig();                                   // header field extremes, with IEND
    put_ihdr(32'hFFFF_FFFF, 32'h0, 8'hFF, 8'h00, 8'h01);
    put_chunk(0, TYPE_IEND);
    ship_file();
    put_sig();
    put_ihdr(32'h0, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h00);
    put_chunk(0, TYPE_IEND);
    ship_file();
    add_byte(8'h00);                             // lone byte: short signature
    ship_file();
    put_sig();                                   // signature broken near its end
    file_q[6] = 8'h1B;
    put_bytes(3);
    ship_file();
    put_sig();                                   // end inside a length prefix
    put_ihdr_random();
    add_byte(8'h00);
    add_byte(8'h00);
    ship_file();
    put_sig();                                   // end inside a payload
    put_ihdr_random();
    put_word(32'd5);
    put_word(32'h7445_5874);
    put_bytes(2);
    ship_file();
    put_sig();                                   // end inside the IHDR CRC
    put_ihdr_random();
    cut_to(file_q.size() - 2);
    ship_file();
    put_sig();                                   // IHDR of the wrong length is ignored
    put_chunk(12, TYPE_IHDR);
    put_chunk(0, TYPE_IEND);
    ship_file();
    put_sig();                                   // second IHDR wins; bytes after IEND counted
    put_ihdr_random();
    put_ihdr_random();
    put_chunk(3, 32'h7445_5874);
    put_chunk(0, TYPE_IEND);
    put_bytes(5);
    ship_file();
    put_sig();                                   // one above the limit
    put_word({7'd0, LIMIT_RESET} + 32'd1);
    put_word($urandom);
    put_bytes(2);
    ship_file();
    put_sig();                                   // all-ones length
    put_ihdr_random();
    put_word(32'hFFFF_FFFF);
    put_bytes(4);
    ship_file();
    put_sig();                                   // exactly the limit passes, then truncated
    put_word({7'd0, LIMIT_RESET});
    put_word(32'h4944_4154);
    put_bytes(3);
    ship_file();

    // zero limit: only empty chunks pass
    set_limit('0);
    put_sig();
    put_chunk(0, TYPE_IEND);
    ship_file();
    put_sig();
    put_word(32'd1);
    put_word(32'h7445_5874);
    put_bytes(2);
    ship_file();

    // limit of one IHDR
    set_limit(LimitW'(13));
    put_sig();
    put_ihdr_random();
    put_chunk(0, TYPE_IEND);
    ship_file();
    put_sig();
    put_ihdr_random();
    put_word(32'd14);
    put_word($urandom);
    ship_file();

    // random phases over several limits
    set_limit(LIMIT_RESET);
    run_random_phase(120, 2);

    set_limit(LimitW'($urandom_range(14, 40)));
    // receiver holds off while single-byte files keep coming: the block fills
    // and must stall its input
    hold_ticket <= hold_ticket + 1;
    steady = 1'b1;
    repeat (16) begin
      put_bytes(1);
      ship_file();
    end
    steady = 1'b0;
    run_random_phase(120, 2);

    set_limit(25'h0FF_FFFF);
    run_random_phase(120, 2);

    set_limit(LimitW'($urandom_range(0, 1 << 24)));
    run_random_phase(120, 2);

    set_limit(LimitW'(13));
    run_random_phase(120, 2);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: png_chunk_header_parser.f
+incdir+design
design/png_cp_pkg.sv
design/png_cp_core.sv
design/png_cp_result.sv
design/png_chunk_header_parser.sv
tb/sv/png_cp_checker.sv
tb/sv/testbench.sv
